/* rtl/core/assert_macros.svh */
// Assertion macros shared by the table RTL.
// Needs nothing else; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be true at a clock edge out of reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

/* rtl/core/milt_pkg.sv */
// Package for the message id table: field widths, stream layout,
// item kinds, table entry and controller/datapath interface structs.
`timescale 1ns / 1ps
package milt_pkg;

    localparam int SLOTS_DEF = 32;

    // payload field widths
    localparam int ID_W   = 24;
    localparam int BYTE_W = 8;
    localparam int ADDR_W = 4 * BYTE_W;
    localparam int TS_W   = 32;
    localparam int SLOT_W = 5;
    localparam int CNT_W  = 6;
    localparam int KIND_W = 2;

    // stream widths
    localparam int IN_DATA_W    = 88;
    localparam int IN_USER_W    = KIND_W;
    localparam int OUT_FIELDS_W = 1 + SLOT_W + ID_W + ADDR_W + TS_W + 1 + CNT_W + 1;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;
    localparam int OUT_FOUND_BIT = 0;
    localparam int OUT_DROP_BIT  = OUT_FIELDS_W - 1;

    typedef enum logic [KIND_W-1:0] {
        KIND_RX     = 2'd0,
        KIND_LOOKUP = 2'd1,
        KIND_LATEST = 2'd2
    } t_kind;

    // one table entry as held in the slot memory
    typedef struct packed {
        logic              upd;
        logic [TS_W-1:0]   ts;
        logic [ADDR_W-1:0] addrs;
        logic [ID_W-1:0]   id;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic scan;
        logic write;
        logic load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic en;
        logic scan_last;
        logic out_free;
    } t_status;

endpackage

/* rtl/core/milt_ctrl.sv */
// Sequencer for the message id table: accept, scan, commit, result.
// Depends on milt_pkg; drives the datapath through t_cmd.
`timescale 1ns / 1ps
module milt_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    input  logic [milt_pkg::KIND_W-1:0]  i_kind,
    output logic                         o_s_tready,
    input  milt_pkg::t_status            i_status,
    output milt_pkg::t_cmd               o_cmd
);
    import milt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DRAIN  = 5'b00100,
        S_WRITE  = 5'b01000,
        S_RESULT = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [KIND_W-1:0]   r_kind, n_kind;
    logic                accept;

    // no transfer is taken while reset is held
    assign o_s_tready = (r_state == S_IDLE) && i_rst_n;
    assign accept     = i_s_tvalid && o_s_tready;

    // next state and commands
    always_comb begin
        n_state       = r_state;
        n_kind        = r_kind;
        o_cmd         = '0;
        o_cmd.start   = accept;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_kind = i_kind;
                    if (!i_status.en || !(i_kind inside {KIND_RX, KIND_LOOKUP, KIND_LATEST})) begin
                        n_state = S_RESULT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last compare lands this cycle
                n_state = (r_kind == KIND_RX) ? S_WRITE : S_RESULT;
            end
            S_WRITE: begin
                o_cmd.write = 1'b1;
                n_state     = S_RESULT;
            end
            S_RESULT: begin
                o_cmd.load_out = i_status.out_free;
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_kind <= n_kind;
    end

endmodule

/* rtl/core/milt_dpath.sv */
// Datapath for the message id table: config register, item register,
// slot memory with scan compare, valid bits, count and result register.
// Depends on milt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module milt_dpath #(
    parameter int SLOTS = milt_pkg::SLOTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  milt_pkg::t_cmd                   i_cmd,
    output milt_pkg::t_status                o_status,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_wdata,
    input  logic [milt_pkg::IN_DATA_W-1:0]   i_s_tdata,
    input  logic [milt_pkg::IN_USER_W-1:0]   i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [milt_pkg::OUT_DATA_W-1:0]  o_m_tdata
);
    import milt_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    // configuration
    logic r_rx_enabled;

    // item register
    logic                r_en;
    logic [KIND_W-1:0]   r_kind;
    logic [ID_W-1:0]     r_id;
    logic [ADDR_W-1:0]   r_addrs;
    logic [TS_W-1:0]     r_ts;

    // slot store
    t_entry              r_mem [SLOTS];
    logic [SLOTS-1:0]    r_valid;
    logic [CW-1:0]       r_count;

    // scan pipeline and trackers
    logic [IW-1:0]       r_addr;
    logic [IW-1:0]       r_cmp_idx;
    logic                r_cmp_en;
    t_entry              r_rd_data;
    logic                r_found;
    logic [IW-1:0]       r_hit_idx;
    t_entry              r_cap;
    logic                r_free_found;
    logic [IW-1:0]       r_free_idx;

    // result register
    logic                    r_out_valid;
    logic [OUT_DATA_W-1:0]   r_out_data, n_out_data;

    logic                cmp_valid;
    logic                stored;
    logic [IW-1:0]       target;

    assign cmp_valid = r_valid[r_cmp_idx];
    assign stored    = r_found || r_free_found;
    assign target    = r_found ? r_hit_idx : r_free_idx;

    assign o_status.en        = r_rx_enabled;
    assign o_status.scan_last = (r_addr == IW'(SLOTS - 1));
    assign o_status.out_free  = !r_out_valid || i_m_tready;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_enabled <= 1'b0;
        end else if (i_cfg_we) begin
            r_rx_enabled <= i_cfg_wdata;
        end
    end

    // item capture on accept
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_en    <= r_rx_enabled;
            r_kind  <= i_s_tuser;
            r_id    <= i_s_tdata[23:0];
            r_addrs <= {i_s_tdata[31:24], i_s_tdata[39:32], i_s_tdata[47:40], i_s_tdata[55:48]};
            r_ts    <= i_s_tdata[87:56];
        end
    end

    // slot memory: one read per scan cycle, one write on commit
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_rd_data <= r_mem[r_addr];
        end
        if (i_cmd.write && stored) begin
            r_mem[target] <= '{upd: 1'b1, ts: r_ts, addrs: r_addrs, id: r_id};
        end
    end

    // scan address and compare stage enable
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_en <= 1'b0;
        end else begin
            r_cmp_en <= i_cmd.scan;
        end
        if (i_cmd.start) begin
            r_addr <= '0;
        end else if (i_cmd.scan) begin
            r_addr <= r_addr + 1'b1;
        end
        r_cmp_idx <= r_addr;
    end

    // compare stage: first id match, first free slot, latest timestamp
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_cap.ts     <= '0;
        end else if (r_cmp_en) begin
            if (r_kind == KIND_LATEST) begin
                if (cmp_valid && (r_rd_data.ts > r_cap.ts)) begin
                    r_found   <= 1'b1;
                    r_hit_idx <= r_cmp_idx;
                    r_cap     <= r_rd_data;
                end
            end else begin
                if (cmp_valid && (r_rd_data.id == r_id) && !r_found) begin
                    r_found   <= 1'b1;
                    r_hit_idx <= r_cmp_idx;
                    r_cap     <= r_rd_data;
                end
                if (!cmp_valid && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_cmp_idx;
                end
            end
        end
    end

    // valid bits and occupied count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else if (i_cmd.write && !r_found && r_free_found) begin
            r_valid[r_free_idx] <= 1'b1;
            r_count             <= r_count + 1'b1;
        end
    end

    // result word
    always_comb begin
        logic          f_found;
        logic          f_drop;
        logic [IW-1:0] f_idx;
        t_entry        f_ent;
        logic [CNT_W-1:0] f_cnt;
        f_found = 1'b0;
        f_drop  = 1'b0;
        f_idx   = r_hit_idx;
        f_ent   = r_cap;
        f_cnt   = r_en ? CNT_W'(r_count) : '0;
        if (r_en) begin
            case (r_kind)
                KIND_RX: begin
                    f_found = stored;
                    f_drop  = !stored;
                    f_idx   = target;
                    f_ent   = '{upd: 1'b1, ts: r_ts, addrs: r_addrs, id: r_id};
                end
                KIND_LOOKUP, KIND_LATEST: begin
                    f_found = r_found;
                end
                default: begin
                    f_found = 1'b0;
                end
            endcase
        end
        if (!f_found) begin
            f_idx = '0;
            f_ent = '0;
        end
        n_out_data = {{OUT_PAD_W{1'b0}}, f_drop, f_cnt, f_ent.upd, f_ent.ts,
                      f_ent.addrs[7:0], f_ent.addrs[15:8], f_ent.addrs[23:16],
                      f_ent.addrs[31:24], f_ent.id, SLOT_W'(f_idx), f_found};
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.load_out) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    `ASSERT_ALWAYS(a_count_matches_valid, i_clk, i_rst_n, $countones(r_valid) == int'(r_count), "occupied count out of step with valid bits")
    `ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, r_count > CW'(SLOTS), "occupied count above table size")
    `ASSERT_ALWAYS(a_alloc_free, i_clk, i_rst_n, (i_cmd.write && !r_found && r_free_found) |-> !r_valid[r_free_idx], "allocation into an occupied slot")
    `ASSERT_NEVER(a_found_and_drop, i_clk, i_rst_n, r_out_valid && r_out_data[OUT_FOUND_BIT] && r_out_data[OUT_DROP_BIT], "result both found and dropped")

endmodule

/* rtl/core/message_id_latest_table.sv */
// Top level of the message id table: stream ports, config port,
// sequencer (milt_ctrl) and datapath (milt_dpath). Depends on milt_pkg.
//
//  channel   | direction | transfer when          | contents
//  s_axis    | in        | tvalid & tready        | tuser kind, tdata item fields
//  m_axis    | out       | tvalid & tready        | tdata result fields
//  cfg       | in        | i_cfg_we               | rx_enabled
//
// Each enabled item scans the slot memory one entry per cycle, then passes a
// drain state, a commit write for receive items and a result state. Disabled
// or unknown-kind items go straight to the result state. Reset is synchronous
// and clears the valid bits at once. A stalled result waits in the output
// register while the next item is taken.
`timescale 1ns / 1ps
module message_id_latest_table #(
    parameter int SLOTS = milt_pkg::SLOTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // config
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_wdata,   // rx_enabled
    // item stream
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // message_id, source_system, source_component, dest_system,
    // dest_component, arrival_time
    input  logic [milt_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    input  logic [milt_pkg::IN_USER_W-1:0]   i_s_axis_tuser,  // kind
    // result stream
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // found, slot, slot_id, slot_source_system, slot_source_component,
    // slot_dest_system, slot_dest_component, slot_time, slot_updated,
    // occupied_count, dropped, zero pad
    output logic [milt_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata
);
    import milt_pkg::*;

    t_cmd    cmd;
    t_status status;

    milt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .i_kind     (i_s_axis_tuser),
        .o_s_tready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    milt_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (i_s_axis_tdata),
        .i_s_tuser   (i_s_axis_tuser),
        .o_m_tvalid  (o_m_axis_tvalid),
        .i_m_tready  (i_m_axis_tready),
        .o_m_tdata   (o_m_axis_tdata)
    );

endmodule

/* sim/message_id_latest_table_tb.sv */
// Self-checking testbench for message_id_latest_table: drives item transfers,
// predicts each result from a local copy of the slot table and compares it.
// Depends on milt_pkg and the message_id_latest_table RTL.
`timescale 1ns / 1ps
module message_id_latest_table_tb;
    import milt_pkg::*;

    localparam int          TABLE_SLOTS  = SLOTS_DEF;
    localparam int          CYCLE_LIMIT  = 600000;
    localparam logic [1:0]  KIND_UNKNOWN = 2'd3;
    localparam int          POOL_SIZE    = 44;

    // item fields as packed into tdata, last member in the lowest bits
    typedef struct packed {
        logic [TS_W-1:0]   arrival;
        logic [BYTE_W-1:0] dst_comp;
        logic [BYTE_W-1:0] dst_sys;
        logic [BYTE_W-1:0] src_comp;
        logic [BYTE_W-1:0] src_sys;
        logic [ID_W-1:0]   msg_id;
    } msg_fields_t;

    // result fields as packed into tdata, last member in the lowest bits
    typedef struct packed {
        logic              dropped;
        logic [CNT_W-1:0]  count;
        logic              updated;
        logic [TS_W-1:0]   ts;
        logic [BYTE_W-1:0] dst_comp;
        logic [BYTE_W-1:0] dst_sys;
        logic [BYTE_W-1:0] src_comp;
        logic [BYTE_W-1:0] src_sys;
        logic [ID_W-1:0]   slot_id;
        logic [SLOT_W-1:0] slot;
        logic              found;
    } slot_report_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic                    i_cfg_wdata = 1'b0;
    logic                    i_s_axis_tvalid = 1'b0;
    logic                    o_s_axis_tready;
    logic [IN_DATA_W-1:0]    i_s_axis_tdata = '0;
    logic [IN_USER_W-1:0]    i_s_axis_tuser = '0;
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   o_m_axis_tdata;

    // local copy of the table and of the enable register
    logic                    rx_en_model = 1'b0;
    logic                    tbl_valid   [TABLE_SLOTS];
    msg_fields_t             tbl_entry   [TABLE_SLOTS];
    logic                    tbl_updated [TABLE_SLOTS];

    slot_report_t            pending_reports[$];
    logic [ID_W-1:0]         id_pool[POOL_SIZE];
    int                      mismatch_count = 0;
    int                      cycle_count = 0;
    bit                      steady_run = 1'b0;

    message_id_latest_table dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    endtask

    // next state of the table and the result for one accepted item
    function automatic slot_report_t predict_slot_report(input logic [1:0] kind,
                                                         input msg_fields_t f);
        slot_report_t r;
        int hit;
        int occupied;
        logic [TS_W-1:0] best;
        r = '0;
        hit = TABLE_SLOTS;
        occupied = 0;
        best = '0;
        if (!rx_en_model)
            return r;
        // id search for receive and lookup
        if (kind == KIND_RX || kind == KIND_LOOKUP) begin
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                if (tbl_valid[i] && tbl_entry[i].msg_id == f.msg_id) begin
                    hit = i;
                    break;
                end
            end
        end
        if (kind == KIND_RX) begin
            // new id claims the lowest free slot
            if (hit == TABLE_SLOTS) begin
                for (int i = 0; i < TABLE_SLOTS; i++) begin
                    if (!tbl_valid[i]) begin
                        hit = i;
                        break;
                    end
                end
                if (hit != TABLE_SLOTS)
                    tbl_valid[hit] = 1'b1;
            end
            if (hit == TABLE_SLOTS) begin
                r.dropped = 1'b1;
            end else begin
                tbl_entry[hit]   = f;
                tbl_updated[hit] = 1'b1;
            end
        end else if (kind == KIND_LATEST) begin
            // strictly greater: lowest slot wins ties, zero never wins
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                if (tbl_valid[i] && tbl_entry[i].arrival > best) begin
                    best = tbl_entry[i].arrival;
                    hit  = i;
                end
            end
        end
        if (hit != TABLE_SLOTS) begin
            r.found    = 1'b1;
            r.slot     = hit[SLOT_W-1:0];
            r.slot_id  = tbl_entry[hit].msg_id;
            r.src_sys  = tbl_entry[hit].src_sys;
            r.src_comp = tbl_entry[hit].src_comp;
            r.dst_sys  = tbl_entry[hit].dst_sys;
            r.dst_comp = tbl_entry[hit].dst_comp;
            r.ts       = tbl_entry[hit].arrival;
            r.updated  = tbl_updated[hit];
        end
        for (int i = 0; i < TABLE_SLOTS; i++)
            if (tbl_valid[i]) occupied++;
        r.count = occupied[CNT_W-1:0];
        return r;
    endfunction

    // result side: compare each transfer, then pick next ready
    always @(posedge i_clk) begin
        slot_report_t got;
        slot_report_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata[OUT_FIELDS_W-1:0];
            if (pending_reports.size() == 0) begin
                report_mismatch($sformatf("unexpected result 0x%0h", got));
            end else begin
                want = pending_reports.pop_front();
                check_field("found",          32'(got.found),    32'(want.found));
                check_field("slot",           32'(got.slot),     32'(want.slot));
                check_field("slot_id",        32'(got.slot_id),  32'(want.slot_id));
                check_field("src_system",     32'(got.src_sys),  32'(want.src_sys));
                check_field("src_component",  32'(got.src_comp), 32'(want.src_comp));
                check_field("dst_system",     32'(got.dst_sys),  32'(want.dst_sys));
                check_field("dst_component",  32'(got.dst_comp), 32'(want.dst_comp));
                check_field("slot_time",      got.ts,            want.ts);
                check_field("slot_updated",   32'(got.updated),  32'(want.updated));
                check_field("occupied_count", 32'(got.count),    32'(want.count));
                check_field("dropped",        32'(got.dropped),  32'(want.dropped));
            end
        end
        i_m_axis_tready <= steady_run || ($urandom_range(0, 99) >= 6);
    end

    // one item transfer; returns at the accepting edge with tvalid still high
    task automatic send_item(input logic [1:0] kind, input msg_fields_t f);
        while (!steady_run && $urandom_range(0, 99) < 6) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= f;
        i_s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_reports.push_back(predict_slot_report(kind, f));
    endtask

    task automatic wait_results_drained();
        i_s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge i_clk);
    endtask

    // register write only with the block idle
    task automatic set_rx_enabled(input logic en);
        wait_results_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= en;
        @(posedge i_clk);
        rx_en_model = en;
        i_cfg_we    <= 1'b0;
    endtask

    function automatic msg_fields_t msg(input logic [ID_W-1:0] id,
                                        input logic [BYTE_W-1:0] ssys,
                                        input logic [BYTE_W-1:0] scomp,
                                        input logic [BYTE_W-1:0] dsys,
                                        input logic [BYTE_W-1:0] dcomp,
                                        input logic [TS_W-1:0] ts);
        msg_fields_t f;
        f.msg_id   = id;
        f.src_sys  = ssys;
        f.src_comp = scomp;
        f.dst_sys  = dsys;
        f.dst_comp = dcomp;
        f.arrival  = ts;
        return f;
    endfunction

    // disabled after reset: nothing stored, every result empty
    task automatic test_disabled_items();
        set_rx_enabled(1'b0);
        send_item(KIND_RX,      msg(24'h000001, 8'h01, 8'h02, 8'h03, 8'h04, 32'd10));
        send_item(KIND_LOOKUP,  msg(24'h000001, 8'h00, 8'h00, 8'h00, 8'h00, 32'd0));
        send_item(KIND_LATEST,  msg(24'h000000, 8'h00, 8'h00, 8'h00, 8'h00, 32'd0));
        send_item(KIND_UNKNOWN, msg(24'hFFFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFFFFFF));
    endtask

    // field extremes, zero timestamp, latest ties, misses, unknown kind
    task automatic test_directed_table();
        set_rx_enabled(1'b1);
        send_item(KIND_LATEST,  msg(24'h000000, 8'h00, 8'h00, 8'h00, 8'h00, 32'd0));
        send_item(KIND_LOOKUP,  msg(24'h000000, 8'h00, 8'h00, 8'h00, 8'h00, 32'd0));
        send_item(KIND_RX,      msg(24'h000000, 8'h00, 8'h00, 8'h00, 8'h00, 32'd0));
        send_item(KIND_LATEST,  msg(24'h000000, 8'h00, 8'h00, 8'h00, 8'h00, 32'd0));
        send_item(KIND_RX,      msg(24'hFFFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFFFFFF));
        send_item(KIND_LATEST,  msg(24'h000000, 8'h00, 8'h00, 8'h00, 8'h00, 32'd0));
        send_item(KIND_RX,      msg(24'h000000, 8'h12, 8'h34, 8'h56, 8'h78, 32'hFFFFFFFF));
        send_item(KIND_LATEST,  msg(24'hFFFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFFFFFF));
        send_item(KIND_LOOKUP,  msg(24'hFFFFFF, 8'h00, 8'h00, 8'h00, 8'h00, 32'd0));
        send_item(KIND_LOOKUP,  msg(24'h5A5A5A, 8'h00, 8'h00, 8'h00, 8'h00, 32'd0));
        send_item(KIND_UNKNOWN, msg(24'h000000, 8'h00, 8'h00, 8'h00, 8'h00, 32'd0));
        send_item(KIND_RX,      msg(24'hA5A5A5, 8'hA5, 8'h5A, 8'hA5, 8'h5A, 32'd1));
    endtask

    // disabling keeps the table, hides it, and ignores receives
    task automatic test_disable_keeps_table();
        set_rx_enabled(1'b0);
        send_item(KIND_RX,     msg(24'h123456, 8'h11, 8'h22, 8'h33, 8'h44, 32'd99));
        send_item(KIND_LOOKUP, msg(24'h000000, 8'h00, 8'h00, 8'h00, 8'h00, 32'd0));
        set_rx_enabled(1'b1);
        send_item(KIND_LOOKUP, msg(24'h123456, 8'h00, 8'h00, 8'h00, 8'h00, 32'd0));
        send_item(KIND_LOOKUP, msg(24'h000000, 8'h00, 8'h00, 8'h00, 8'h00, 32'd0));
    endtask

    // mixed traffic over a small id pool so hits, updates and drops all occur
    task automatic test_random_traffic(input int n_items, input int steady_items);
        logic [1:0]  kind;
        msg_fields_t f;
        int          pick;
        for (int k = 0; k < n_items; k++) begin
            steady_run = (k < steady_items);
            pick = $urandom_range(0, 99);
            if (pick < 50)      kind = KIND_RX;
            else if (pick < 75) kind = KIND_LOOKUP;
            else if (pick < 95) kind = KIND_LATEST;
            else                kind = KIND_UNKNOWN;
            f = IN_DATA_W'({$urandom, $urandom, $urandom});
            if ($urandom_range(0, 99) < 85)
                f.msg_id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
            // timestamps bunched to give zeros and ties
            case ($urandom_range(0, 9))
                0:       f.arrival = '0;
                1:       f.arrival = '1;
                2, 3:    f.arrival = $urandom_range(0, 3);
                default: f.arrival = $urandom;
            endcase
            send_item(kind, f);
            if (k % 150 == 149)
                wait_results_drained();
        end
        steady_run = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            tbl_valid[i]   = 1'b0;
            tbl_entry[i]   = '0;
            tbl_updated[i] = 1'b0;
        end
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            id_pool[i] = ID_W'($urandom);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_disabled_items();
        test_directed_table();
        test_disable_keeps_table();
        test_random_traffic(900, 0);
        set_rx_enabled(1'b0);
        test_random_traffic(150, 0);
        set_rx_enabled(1'b1);
        test_random_traffic(950, 300);

        wait_results_drained();
        repeat (TABLE_SLOTS + 8) @(posedge i_clk);
        if (pending_reports.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_reports.size()));
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
